// ----- src/paced_stereo_pwm_sample_fifo_unit_assert.svh -----
// assertion macros used by the checker file
`ifndef PACED_STEREO_PWM_SAMPLE_FIFO_UNIT_ASSERT_SVH
`define PACED_STEREO_PWM_SAMPLE_FIFO_UNIT_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define PSFIFO_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("psfifo check failed");

// next-cycle implication, disabled while reset is low
`define PSFIFO_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("psfifo check failed");

`endif

// ----- src/psfifo_pkg.sv -----
package psfifo_pkg;

  // ring and pwm sizing
  localparam int RING_DEPTH = 512;
  localparam int PWM_TOP    = 1024;
  localparam int PTR_W      = $clog2(RING_DEPTH);
  localparam int CNT_W      = $clog2(RING_DEPTH + 1);

  // fixed field widths
  localparam int WORD_W   = 32;
  localparam int HALF_W   = 16;
  localparam int FRAC_W   = 16;
  localparam int TICK_W   = 17;
  localparam int FREE_W   = 10;
  localparam int LEVEL_W  = 11;
  localparam int ODATA_W  = 40;

  // reset values
  localparam logic [WORD_W-1:0]  PERIOD_RESET = 32'd2972154;
  localparam logic [TICK_W-1:0]  TICKS_RESET  =
    ((PERIOD_RESET >> FRAC_W) == 0) ? TICK_W'(1) : TICK_W'(PERIOD_RESET >> FRAC_W);
  localparam logic [LEVEL_W-1:0] LEVEL_MID    = LEVEL_W'(PWM_TOP / 2);

  // configuration register indexes
  localparam logic [1:0] REG_SAMPLE_PERIOD = 2'd0;
  localparam logic [1:0] REG_SWAP_CHANNELS = 2'd1;
  localparam logic [1:0] REG_ENABLE        = 2'd2;

  // input kinds carried in tuser
  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_TICK   = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_POP
  } psfifo_state_t;

  typedef struct packed {
    logic               underrun;
    logic               level_changed;
    logic [LEVEL_W-1:0] level_b;
    logic [LEVEL_W-1:0] level_a;
    logic [FREE_W-1:0]  free_slots;
    logic               accepted;
  } psfifo_res_t;

  // signed half to pwm level: (s + 32768) * PWM_TOP >> 16
  function automatic logic [LEVEL_W-1:0] half_to_level(input logic [HALF_W-1:0] half);
    logic [HALF_W-1:0]   biased;
    logic [HALF_W+17:0]  prod;
    biased = half ^ {1'b1, {(HALF_W-1){1'b0}}};
    prod   = (HALF_W+18)'(biased) * (HALF_W+18)'(PWM_TOP);
    return LEVEL_W'(prod >> HALF_W);
  endfunction

endpackage

// ----- src/paced_stereo_pwm_sample_fifo_unit.sv -----
// sample enqueue, disabled tick and non-expiring tick: result one cycle after the transfer
// expiring tick that pops the ring: result two cycles after, via the one-cycle ring read
// next item is taken once the item before has its result queued: 1 cycle, or 2 when popping
// a two-entry result queue lets new items in while up to two results wait downstream
// reset: pointers, count and fraction cleared, countdown to the reset period, levels mid-scale
// no clearing pass: ring contents stay undefined until written
module paced_stereo_pwm_sample_fifo_unit
  import psfifo_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // input stream
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [WORD_W-1:0]   in_tdata,   // [31:0] sample_word
  input  logic                in_tuser,   // [0] mode
  // result stream
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [ODATA_W-1:0]  out_tdata,  // [0] accepted, [10:1] free_slots, [21:11] level_a,
                                          // [32:22] level_b, [33] level_changed,
                                          // [34] underrun, [39:35] zero
  // configuration writes
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [WORD_W-1:0]   cfg_data
);

  psfifo_state_t       state_r, state_nxt;
  logic [PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [FRAC_W-1:0]   frac_r, frac_nxt;
  logic [TICK_W-1:0]   ticks_r, ticks_nxt;
  logic [LEVEL_W-1:0]  level_a_r, level_a_nxt;
  logic [LEVEL_W-1:0]  level_b_r, level_b_nxt;
  logic [WORD_W-1:0]   period_r;
  logic                swap_r;
  logic                enable_r;

  logic [WORD_W-1:0]   ring [RING_DEPTH];
  logic [WORD_W-1:0]   rd_data_r;
  logic                mem_we;
  logic                mem_re;

  logic                in_fire;
  logic                cfg_fire;
  logic [WORD_W:0]     acc_sum;
  logic [TICK_W-1:0]   delay;
  logic [LEVEL_W-1:0]  lvl_left;
  logic [LEVEL_W-1:0]  lvl_right;

  logic                push;
  psfifo_res_t         push_res;
  logic                res_accepted;
  logic                res_changed;
  logic                res_under;

  psfifo_res_t         q0_r, q1_r;
  logic [1:0]          q_cnt_r;
  logic                pop;

  assign in_tready = (state_r == ST_IDLE) && (q_cnt_r != 2'd2);
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  // pacer arithmetic and level mapping
  assign acc_sum   = (WORD_W+1)'(frac_r) + (WORD_W+1)'(period_r);
  assign delay     = TICK_W'(acc_sum >> FRAC_W);
  assign lvl_left  = half_to_level(rd_data_r[WORD_W-1:HALF_W]);
  assign lvl_right = half_to_level(rd_data_r[HALF_W-1:0]);

  // next state, ring access and result
  always_comb begin
    state_nxt    = state_r;
    wr_ptr_nxt   = wr_ptr_r;
    rd_ptr_nxt   = rd_ptr_r;
    count_nxt    = count_r;
    frac_nxt     = frac_r;
    ticks_nxt    = ticks_r;
    level_a_nxt  = level_a_r;
    level_b_nxt  = level_b_r;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    push         = 1'b0;
    res_accepted = 1'b0;
    res_changed  = 1'b0;
    res_under    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_tuser == MODE_SAMPLE) begin
            push = 1'b1;
            if (count_r < CNT_W'(RING_DEPTH)) begin
              mem_we       = 1'b1;
              wr_ptr_nxt   = (wr_ptr_r == PTR_W'(RING_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
              count_nxt    = count_r + 1'b1;
              res_accepted = 1'b1;
            end
          end else if (enable_r) begin
            if (ticks_r > TICK_W'(1)) begin
              ticks_nxt = ticks_r - 1'b1;
              push      = 1'b1;
            end else begin
              frac_nxt  = acc_sum[FRAC_W-1:0];
              ticks_nxt = (delay == '0) ? TICK_W'(1) : delay;
              if (count_r == '0) begin
                push      = 1'b1;
                res_under = 1'b1;
              end else begin
                mem_re     = 1'b1;
                rd_ptr_nxt = (rd_ptr_r == PTR_W'(RING_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
                count_nxt  = count_r - 1'b1;
                state_nxt  = ST_POP;
              end
            end
          end else begin
            push = 1'b1;
          end
        end
      end
      ST_POP: begin
        level_a_nxt = swap_r ? lvl_right : lvl_left;
        level_b_nxt = swap_r ? lvl_left  : lvl_right;
        res_changed = 1'b1;
        push        = 1'b1;
        state_nxt   = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    // a period write restarts the fraction
    if (cfg_fire && (cfg_index == REG_SAMPLE_PERIOD)) begin
      frac_nxt = '0;
    end
    push_res.accepted      = res_accepted;
    push_res.free_slots    = FREE_W'(CNT_W'(RING_DEPTH) - count_nxt);
    push_res.level_a       = level_a_nxt;
    push_res.level_b       = level_b_nxt;
    push_res.level_changed = res_changed;
    push_res.underrun      = res_under;
  end

  // control and pacer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      wr_ptr_r  <= '0;
      rd_ptr_r  <= '0;
      count_r   <= '0;
      frac_r    <= '0;
      ticks_r   <= TICKS_RESET;
      level_a_r <= LEVEL_MID;
      level_b_r <= LEVEL_MID;
    end else begin
      state_r   <= state_nxt;
      wr_ptr_r  <= wr_ptr_nxt;
      rd_ptr_r  <= rd_ptr_nxt;
      count_r   <= count_nxt;
      frac_r    <= frac_nxt;
      ticks_r   <= ticks_nxt;
      level_a_r <= level_a_nxt;
      level_b_r <= level_b_nxt;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= PERIOD_RESET;
      swap_r   <= 1'b0;
      enable_r <= 1'b0;
    end else if (cfg_fire) begin
      case (cfg_index)
        REG_SAMPLE_PERIOD: period_r <= cfg_data;
        REG_SWAP_CHANNELS: swap_r   <= cfg_data[0];
        REG_ENABLE:        enable_r <= cfg_data[0];
        default:           ;
      endcase
    end
  end

  // sample ring, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring[wr_ptr_r] <= in_tdata;
    end
    if (mem_re) begin
      rd_data_r <= ring[rd_ptr_r];
    end
  end

  // two-entry result queue, head drives the output
  assign pop = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_cnt_r <= '0;
    end else begin
      q_cnt_r <= q_cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push && ((q_cnt_r == 2'd0) || (pop && (q_cnt_r == 2'd1)))) begin
      q0_r <= push_res;
    end else if (pop && (q_cnt_r == 2'd2)) begin
      q0_r <= q1_r;
    end
    if (push && (((q_cnt_r == 2'd1) && !pop) || ((q_cnt_r == 2'd2) && pop))) begin
      q1_r <= push_res;
    end
  end

  assign out_tvalid = (q_cnt_r != 2'd0);
  assign out_tdata  = {(ODATA_W - $bits(psfifo_res_t))'(0), q0_r};

endmodule

// ----- src/psfifo_checker.sv -----
`include "paced_stereo_pwm_sample_fifo_unit_assert.svh"

module psfifo_checker
  import psfifo_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               out_tvalid,
  input logic               out_tready,
  input logic [ODATA_W-1:0] out_tdata
);

  // result fields used by the checks
  logic              res_accepted;
  logic              res_changed;
  logic              res_under;
  logic [FREE_W-1:0] res_free;

  assign res_accepted = out_tdata[0];
  assign res_free     = out_tdata[10:1];
  assign res_changed  = out_tdata[33];
  assign res_under    = out_tdata[34];

  // a result never both updates the levels and reports an underrun
  `PSFIFO_ASSERT_IMP(a_changed_xor_under, clk, rst_n, out_tvalid, !(res_changed && res_under))

  // a stored sample comes only from an enqueue, never with pacer flags
  `PSFIFO_ASSERT_IMP(a_accept_no_pacer, clk, rst_n, out_tvalid && res_accepted, !res_changed && !res_under)

  // free slots never exceed the ring depth
  `PSFIFO_ASSERT_IMP(a_free_range, clk, rst_n, out_tvalid, res_free <= FREE_W'(RING_DEPTH))

  // a stalled result stays offered
  `PSFIFO_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid)

  // a stalled result keeps its payload
  `PSFIFO_ASSERT_NXT(a_out_stable, clk, rst_n, out_tvalid && !out_tready, $stable(out_tdata))

endmodule

bind paced_stereo_pwm_sample_fifo_unit psfifo_checker u_psfifo_checker (.*);

// ----- sim/paced_stereo_pwm_sample_fifo_unit_tb.sv -----
module paced_stereo_pwm_sample_fifo_unit_tb;
  import psfifo_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 4;
  localparam int HOLD_OFF_LEN  = 150;

  localparam logic [WORD_W-1:0] PERIOD_ONE_US   = 32'h0001_0000;
  localparam logic [WORD_W-1:0] PERIOD_ONE_HALF = 32'h0001_8000;
  localparam logic [WORD_W-1:0] PERIOD_LONGEST  = 32'hFFFF_FFFF;
  localparam logic [HALF_W-1:0] HALF_BIAS       = 16'h8000;

  logic               clk;
  logic               rst_n;
  logic               in_tvalid;
  logic               in_tready;
  logic [WORD_W-1:0]  in_tdata;
  logic               in_tuser;
  logic               out_tvalid;
  logic               out_tready;
  logic [ODATA_W-1:0] out_tdata;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [1:0]         cfg_index;
  logic [WORD_W-1:0]  cfg_data;

  paced_stereo_pwm_sample_fifo_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // predictor state: ring contents, pacer and held levels
  logic [WORD_W-1:0]  ring_words[$];
  logic [WORD_W-1:0]  period_q    = PERIOD_RESET;
  logic               swap_q      = 1'b0;
  logic               enable_q    = 1'b0;
  logic [FRAC_W-1:0]  frac_q      = '0;
  logic [TICK_W-1:0]  countdown_q = TICKS_RESET;
  logic [LEVEL_W-1:0] level_a_q   = LEVEL_MID;
  logic [LEVEL_W-1:0] level_b_q   = LEVEL_MID;

  psfifo_res_t pending_pacer_results[$];

  int errors             = 0;
  int cycle_count        = 0;
  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;
  int hold_left          = 0;

  // free-running clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // signed half to pwm compare level
  function automatic logic [LEVEL_W-1:0] pwm_level_of(input logic [HALF_W-1:0] half);
    logic [31:0] scaled;
    scaled = 32'(half ^ HALF_BIAS) * PWM_TOP;
    return LEVEL_W'(scaled >> HALF_W);
  endfunction

  // work out the result of one accepted item and queue it
  task automatic compute_pacer_result(input logic mode, input logic [WORD_W-1:0] word);
    psfifo_res_t       res;
    logic [32:0]       acc;
    logic [WORD_W-1:0] popped;
    res = '0;
    if (mode == MODE_SAMPLE) begin
      if (ring_words.size() < RING_DEPTH) begin
        ring_words.push_back(word);
        res.accepted = 1'b1;
      end
    end else if (enable_q) begin
      if (countdown_q > 1) begin
        countdown_q = countdown_q - 1'b1;
      end else begin
        // pacer expiry: fractional reload, then pop or underrun
        acc         = {17'd0, frac_q} + {1'b0, period_q};
        countdown_q = (acc[32:16] == '0) ? TICK_W'(1) : acc[32:16];
        frac_q      = acc[15:0];
        if (ring_words.size() == 0) begin
          res.underrun = 1'b1;
        end else begin
          popped = ring_words.pop_front();
          if (swap_q) begin
            level_a_q = pwm_level_of(popped[15:0]);
            level_b_q = pwm_level_of(popped[31:16]);
          end else begin
            level_a_q = pwm_level_of(popped[31:16]);
            level_b_q = pwm_level_of(popped[15:0]);
          end
          res.level_changed = 1'b1;
        end
      end
    end
    res.free_slots = FREE_W'(RING_DEPTH - ring_words.size());
    res.level_a    = level_a_q;
    res.level_b    = level_b_q;
    pending_pacer_results.push_back(res);
  endtask

  // offer one item, with random idle cycles ahead of it
  task automatic send_item(input logic mode, input logic [WORD_W-1:0] word);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= word;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    compute_pacer_result(mode, word);
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_pacer_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register write, only with the block idle
  task automatic write_reg(input logic [1:0] idx, input logic [WORD_W-1:0] data);
    drain_results();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_SAMPLE_PERIOD: begin
        period_q = data;
        frac_q   = '0;
      end
      REG_SWAP_CHANNELS: swap_q = data[0];
      REG_ENABLE:        enable_q = data[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_idling(input int idle_pct, input int stall_pct);
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
  endtask

  // disabled ticks and the extremes of the sample halves
  task automatic test_disabled_and_extremes();
    set_idling(0, 0);
    send_item(MODE_TICK, 32'hFFFF_FFFF);
    send_item(MODE_SAMPLE, 32'h8000_0000);
    send_item(MODE_SAMPLE, 32'h7FFF_7FFF);
    send_item(MODE_SAMPLE, 32'h8000_7FFF);
    send_item(MODE_SAMPLE, 32'h7FFF_8000);
    send_item(MODE_SAMPLE, 32'h0000_0000);
    send_item(MODE_SAMPLE, 32'hFFFF_FFFF);
    send_item(MODE_SAMPLE, 32'h0001_0001);
    send_item(MODE_TICK, 32'h0000_0000);
  endtask

  // reset countdown, period change, swapping and underrun
  task automatic test_countdown_and_swap();
    write_reg(REG_ENABLE, 32'd1);
    while (countdown_q > 1) send_item(MODE_TICK, $urandom);
    send_item(MODE_TICK, $urandom);
    write_reg(REG_SAMPLE_PERIOD, PERIOD_ONE_US);
    while (countdown_q > 1) send_item(MODE_TICK, $urandom);
    send_item(MODE_TICK, $urandom);
    write_reg(REG_SWAP_CHANNELS, 32'd1);
    send_item(MODE_TICK, $urandom);
    send_item(MODE_TICK, $urandom);
    write_reg(REG_SWAP_CHANNELS, 32'd0);
    send_item(MODE_TICK, $urandom);
    // one and a half microseconds: reloads alternate between one and two
    write_reg(REG_SAMPLE_PERIOD, PERIOD_ONE_HALF);
    repeat (7) send_item(MODE_TICK, $urandom);
  endtask

  // random mix of samples and ticks under one idling setting
  task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                     input int n_items);
    int tick_pct;
    logic [WORD_W-1:0] period;
    case ($urandom_range(3))
      0:       period = PERIOD_ONE_US;
      1:       period = PERIOD_ONE_US + $urandom_range(16'hFFFF);
      2:       period = $urandom_range(32'h0001_0000, 32'h0003_FFFF);
      default: period = $urandom_range(32'h0001_0000, 32'h0001_FFFF);
    endcase
    write_reg(REG_SAMPLE_PERIOD, period);
    write_reg(REG_SWAP_CHANNELS, $urandom_range(1));
    write_reg(REG_ENABLE, 32'($urandom_range(3) != 0));
    set_idling(idle_pct, stall_pct);
    tick_pct = $urandom_range(40, 85);
    repeat (n_items) begin
      if ($urandom_range(99) < tick_pct) send_item(MODE_TICK, $urandom);
      else send_item(MODE_SAMPLE, $urandom);
    end
  endtask

  // receiver holds off while items keep coming, then the sender waits it out
  task automatic test_output_hold_off();
    write_reg(REG_ENABLE, 32'd1);
    set_idling(0, 0);
    hold_left = HOLD_OFF_LEN;
    repeat (24) begin
      if ($urandom_range(1)) send_item(MODE_TICK, $urandom);
      else send_item(MODE_SAMPLE, $urandom);
    end
    drain_results();
  endtask

  // fill the ring past full with pacing off, then pop near the top
  task automatic test_ring_overflow();
    write_reg(REG_ENABLE, 32'd0);
    set_idling(23, 23);
    repeat (RING_DEPTH + 8) send_item(MODE_SAMPLE, $urandom);
    send_item(MODE_TICK, $urandom);
    write_reg(REG_SAMPLE_PERIOD, PERIOD_ONE_US);
    write_reg(REG_ENABLE, 32'd1);
    repeat (6) begin
      send_item(MODE_TICK, $urandom);
      send_item(MODE_SAMPLE, $urandom);
      send_item(MODE_SAMPLE, $urandom);
    end
  endtask

  // largest period: one expiry, then a long countdown
  task automatic test_longest_period();
    set_idling(0, 0);
    write_reg(REG_SAMPLE_PERIOD, PERIOD_LONGEST);
    send_item(MODE_TICK, $urandom);
    repeat (6) send_item(MODE_TICK, $urandom);
    send_item(MODE_SAMPLE, $urandom);
  endtask

  // receiver: long hold-off first, otherwise random stalls
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left = hold_left - 1;
      end else begin
        out_tready <= ($urandom_range(99) >= receiver_stall_pct);
      end
    end
  end

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  // compare each result transfer with the oldest prediction
  initial begin
    psfifo_res_t want;
    psfifo_res_t got;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        if (pending_pacer_results.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %h", $time, out_tdata);
          errors++;
        end else begin
          want = pending_pacer_results.pop_front();
          got  = psfifo_res_t'(out_tdata[34:0]);
          check_field("accepted", 32'(want.accepted), 32'(got.accepted));
          check_field("free_slots", 32'(want.free_slots), 32'(got.free_slots));
          check_field("level_a", 32'(want.level_a), 32'(got.level_a));
          check_field("level_b", 32'(want.level_b), 32'(got.level_b));
          check_field("level_changed", 32'(want.level_changed), 32'(got.level_changed));
          check_field("underrun", 32'(want.underrun), 32'(got.underrun));
          check_field("padding", 32'd0, 32'(out_tdata[ODATA_W-1:35]));
        end
      end
    end
  end

  // run limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("status: fail");
    $finish;
  end

  // stimulus
  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = MODE_SAMPLE;
    cfg_valid = 1'b0;
    cfg_index = REG_SAMPLE_PERIOD;
    cfg_data  = '0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    test_disabled_and_extremes();
    test_countdown_and_swap();
    test_random_traffic(0, 0, 110);
    test_random_traffic(62, 0, 110);
    test_random_traffic(0, 62, 110);
    test_random_traffic(23, 23, 110);
    test_output_hold_off();
    test_ring_overflow();
    test_longest_period();

    drain_results();
    if (errors == 0 && pending_pacer_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+src
src/psfifo_pkg.sv
src/paced_stereo_pwm_sample_fifo_unit.sv
src/psfifo_checker.sv
sim/paced_stereo_pwm_sample_fifo_unit_tb.sv
